[sv/tvs_pkg.sv]
// ----------------------------------------------------------------------------
// tvs_pkg
// Types and fixed widths shared by the trilinear volume splat block.
// ----------------------------------------------------------------------------
package tvs_pkg;

	localparam int COORD_W = 16;
	localparam int COUNT_W = 16;
	localparam int WSUM_W  = 32;
	localparam int ISUM_W  = 48;
	localparam int Q16_W   = 17;   // corner weight, Q0.16 up to 1.0
	localparam int WPROD_W = 33;   // corner weight times count

	localparam logic OP_SPLAT = 1'b0;
	localparam logic OP_READ  = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MXY,
		ST_MZ,
		ST_RND,
		ST_MCNT,
		ST_WR,
		ST_RDA,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		ALU_MUL_XY,
		ALU_MUL_Z,
		ALU_ROUND,
		ALU_MUL_CNT
	} alu_op_t;

	typedef struct packed {
		logic    en;
		alu_op_t op;
	} alu_ctrl_t;

	typedef struct packed {
		logic we;
		logic re;
		logic clr;
	} ram_ctrl_t;

endpackage

[sv/tvs_if.sv]
// ----------------------------------------------------------------------------
// tvs_in_if / tvs_out_if
// Valid/ready channels for splat and read requests and their results.
// ----------------------------------------------------------------------------
interface tvs_in_if
	import tvs_pkg::*;
();
	logic                      valid;
	logic                      ready;
	logic                      opcode;
	logic signed [COORD_W-1:0] coord_x;
	logic signed [COORD_W-1:0] coord_y;
	logic signed [COORD_W-1:0] coord_z;
	logic [COUNT_W-1:0]        photon_count;

	modport source (output valid, opcode, coord_x, coord_y, coord_z, photon_count,
		input ready);
	modport sink (input valid, opcode, coord_x, coord_y, coord_z, photon_count,
		output ready);
endinterface

interface tvs_out_if
	import tvs_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              in_range;
	logic [WSUM_W-1:0] weight_sum;
	logic [ISUM_W-1:0] intensity_sum;

	modport source (output valid, in_range, weight_sum, intensity_sum, input ready);
	modport sink (input valid, in_range, weight_sum, intensity_sum, output ready);
endinterface

[sv/tvs_ram.sv]
// ----------------------------------------------------------------------------
// tvs_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module tvs_ram #(
	parameter int WIDTH  = 32,
	parameter int ADDR_W = 15
) (
	input  logic              clk,
	input  logic              we,
	input  logic              re,
	input  logic [ADDR_W-1:0] addr,
	input  logic [WIDTH-1:0]  wdata,
	output logic [WIDTH-1:0]  rdata
);

	localparam int DEPTH = 1 << ADDR_W;

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

[sv/tvs_alu.sv]
// ----------------------------------------------------------------------------
// tvs_alu
// Shared multiplier: forms a corner weight in three passes, then the
// weighted count in a fourth.
// ----------------------------------------------------------------------------
module tvs_alu
	import tvs_pkg::*;
#(
	parameter int FRAC_BITS = 8
) (
	input  logic                 clk,
	input  alu_ctrl_t            ctrl,
	input  logic [FRAC_BITS:0]   wx,
	input  logic [FRAC_BITS:0]   wy,
	input  logic [FRAC_BITS:0]   wz,
	input  logic [COUNT_W-1:0]   count,
	output logic [Q16_W-1:0]     weight,
	output logic [WPROD_W-1:0]   wprod
);

	localparam int FW   = FRAC_BITS + 1;
	localparam int P1W  = 2 * FRAC_BITS + 1;
	localparam int PW   = 3 * FRAC_BITS + 1;
	localparam int MA   = (P1W > Q16_W) ? P1W : Q16_W;
	localparam int MB   = (FW > COUNT_W) ? FW : COUNT_W;
	localparam int PRW  = MA + MB;
	localparam int S3   = 3 * FRAC_BITS;
	localparam int RSH  = (S3 > 16) ? S3 - 16 : 0;
	localparam int LSH  = (S3 > 16) ? 0 : 16 - S3;
	localparam logic [PW:0] RNDV = (PW + 1)'((1 << RSH) >> 1);

	logic [PRW-1:0]   acc_q;
	logic [Q16_W-1:0] w_q;
	logic [MA-1:0]    a_mux;
	logic [MB-1:0]    b_mux;
	logic [PRW-1:0]   prod;
	logic [PW:0]      rsum;
	logic [Q16_W-1:0] w_next;

	always_comb begin
		a_mux = MA'(wx);
		b_mux = MB'(wy);
		unique case (ctrl.op)
			ALU_MUL_XY: begin
				a_mux = MA'(wx);
				b_mux = MB'(wy);
			end
			ALU_MUL_Z: begin
				a_mux = MA'(acc_q[P1W-1:0]);
				b_mux = MB'(wz);
			end
			ALU_ROUND: begin
				a_mux = MA'(w_q);
				b_mux = MB'(count);
			end
			ALU_MUL_CNT: begin
				a_mux = MA'(w_q);
				b_mux = MB'(count);
			end
			default: begin
				a_mux = MA'(wx);
				b_mux = MB'(wy);
			end
		endcase
	end

	assign prod   = a_mux * b_mux;
	// round half up into Q0.16, or widen when the fraction is short
	assign rsum   = (PW + 1)'(acc_q[PW-1:0]) + RNDV;
	assign w_next = Q16_W'(rsum >> RSH) << LSH;

	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			if (ctrl.op == ALU_ROUND) begin
				w_q <= w_next;
			end else begin
				acc_q <= prod;
			end
		end
	end

	assign weight = w_q;
	assign wprod  = acc_q[WPROD_W-1:0];

endmodule

[sv/trilinear_volume_splat.sv]
// Splat: per corner, three multiplier passes for the weight, one for weight
// times count and one store write. Read: one store read. Out-of-range item:
// no store access. Each item ends in OUT, which waits for the result port.
// One item at a time. Reset: both stores are cleared by a pass over all
// 2^(3*clog2(SIDE)) addresses (32768 at SIDE = 32), accepting no item.
// ----------------------------------------------------------------------------
// trilinear_volume_splat
// Trilinear splatting of samples into weight and intensity volumes with
// saturating accumulation, and voxel readback.
// ----------------------------------------------------------------------------
module trilinear_volume_splat
	import tvs_pkg::*;
#(
	parameter int SIDE      = 32,
	parameter int FRAC_BITS = 8
) (
	input logic           clk,
	input logic           arst_n,
	tvs_in_if.sink        sample,
	tvs_out_if.source     result
);

	localparam int AW     = $clog2(SIDE);
	localparam int ADDR_W = 3 * AW;
	localparam int IPW    = COORD_W - FRAC_BITS;
	localparam int EW     = (IPW > AW) ? IPW : AW;
	localparam int FW     = FRAC_BITS + 1;
	localparam logic [FW-1:0] ONE = FW'(1) << FRAC_BITS;

	state_t state_q, state_d;
	alu_ctrl_t alu_ctrl;
	ram_ctrl_t ram_ctrl;

	logic [2:0][COORD_W-1:0]   raw;
	logic [2:0][EW-1:0]        ipx;
	logic                      neg, rd_ok, sp_ok;
	logic                      accept;

	logic [2:0][AW-1:0]        ip_q;
	logic [2:0][FRAC_BITS-1:0] fr_q;
	logic [COUNT_W-1:0]        count_q;
	logic                      read_q;
	logic                      range_q;
	logic [2:0]                corner_q;
	logic [ADDR_W-1:0]         clr_cnt_q;

	logic [2:0][FW-1:0]        wsel;
	logic [2:0][AW-1:0]        cpos;
	logic [ADDR_W-1:0]         addr;

	logic [Q16_W-1:0]          weight;
	logic [WPROD_W-1:0]        wprod;
	logic [WSUM_W-1:0]         rd_w, wr_w;
	logic [ISUM_W-1:0]         rd_i, wr_i;
	logic [WSUM_W:0]           wsum;
	logic [ISUM_W:0]           isum;

	logic                      out_valid_q;
	logic                      res_range_q;
	logic [WSUM_W-1:0]         res_w_q;
	logic [ISUM_W-1:0]         res_i_q;
	logic                      out_free;

	assign sample.ready = (state_q == ST_IDLE);
	assign accept       = sample.valid && sample.ready;
	assign out_free     = !out_valid_q || result.ready;

	// decode the incoming coordinate
	assign raw = {sample.coord_x, sample.coord_y, sample.coord_z};

	always_comb begin
		neg   = 1'b0;
		rd_ok = 1'b1;
		sp_ok = 1'b1;
		for (int a = 0; a < 3; a++) begin
			ipx[a] = EW'(raw[a][COORD_W-1:FRAC_BITS]);
			neg    = neg | raw[a][COORD_W-1];
			rd_ok  = rd_ok & (ipx[a] < SIDE);
			sp_ok  = sp_ok & (ipx[a] < SIDE - 1);
		end
	end

	// corner factors and address; corner bit 2 is x, bit 0 is z
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			wsel[a] = corner_q[a] ? FW'(fr_q[a]) : ONE - FW'(fr_q[a]);
			cpos[a] = ip_q[a] + AW'(corner_q[a]);
		end
	end

	assign addr = ram_ctrl.clr ? clr_cnt_q : {cpos[2], cpos[1], cpos[0]};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_cnt_q == '1) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					if (sample.opcode == OP_READ) begin
						state_d = (rd_ok && !neg) ? ST_RDA : ST_OUT;
					end else begin
						state_d = (sp_ok && !neg) ? ST_MXY : ST_OUT;
					end
				end
			end
			ST_MXY:  state_d = ST_MZ;
			ST_MZ:   state_d = ST_RND;
			ST_RND:  state_d = ST_MCNT;
			ST_MCNT: state_d = ST_WR;
			ST_WR: begin
				state_d = (corner_q == 3'd7) ? ST_OUT : ST_MXY;
			end
			ST_RDA:  state_d = ST_OUT;
			ST_OUT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// control outputs
	always_comb begin
		alu_ctrl = '{en: 1'b0, op: ALU_MUL_XY};
		ram_ctrl = '{we: 1'b0, re: 1'b0, clr: 1'b0};
		unique case (state_q)
			ST_CLEAR: ram_ctrl = '{we: 1'b1, re: 1'b0, clr: 1'b1};
			ST_MXY: begin
				alu_ctrl = '{en: 1'b1, op: ALU_MUL_XY};
				ram_ctrl.re = 1'b1;
			end
			ST_MZ:   alu_ctrl = '{en: 1'b1, op: ALU_MUL_Z};
			ST_RND:  alu_ctrl = '{en: 1'b1, op: ALU_ROUND};
			ST_MCNT: alu_ctrl = '{en: 1'b1, op: ALU_MUL_CNT};
			ST_WR:   ram_ctrl.we = 1'b1;
			ST_RDA:  ram_ctrl.re = 1'b1;
			default: begin
				alu_ctrl = '{en: 1'b0, op: ALU_MUL_XY};
				ram_ctrl = '{we: 1'b0, re: 1'b0, clr: 1'b0};
			end
		endcase
	end

	tvs_alu #(
		.FRAC_BITS (FRAC_BITS)
	) u_alu (
		.clk    (clk),
		.ctrl   (alu_ctrl),
		.wx     (wsel[2]),
		.wy     (wsel[1]),
		.wz     (wsel[0]),
		.count  (count_q),
		.weight (weight),
		.wprod  (wprod)
	);

	// saturating accumulate
	assign wsum = (WSUM_W + 1)'(rd_w) + (WSUM_W + 1)'(weight);
	assign isum = (ISUM_W + 1)'(rd_i) + (ISUM_W + 1)'(wprod);
	assign wr_w = ram_ctrl.clr ? '0 : (wsum[WSUM_W] ? '1 : wsum[WSUM_W-1:0]);
	assign wr_i = ram_ctrl.clr ? '0 : (isum[ISUM_W] ? '1 : isum[ISUM_W-1:0]);

	tvs_ram #(
		.WIDTH  (WSUM_W),
		.ADDR_W (ADDR_W)
	) u_weight_ram (
		.clk   (clk),
		.we    (ram_ctrl.we),
		.re    (ram_ctrl.re),
		.addr  (addr),
		.wdata (wr_w),
		.rdata (rd_w)
	);

	tvs_ram #(
		.WIDTH  (ISUM_W),
		.ADDR_W (ADDR_W)
	) u_intensity_ram (
		.clk   (clk),
		.we    (ram_ctrl.we),
		.re    (ram_ctrl.re),
		.addr  (addr),
		.wdata (wr_i),
		.rdata (rd_i)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			corner_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (accept) begin
				corner_q <= '0;
			end else if (state_q == ST_WR) begin
				corner_q <= corner_q + 1'b1;
			end
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int a = 0; a < 3; a++) begin
				ip_q[a] <= ipx[a][AW-1:0];
				fr_q[a] <= raw[a][FRAC_BITS-1:0];
			end
			count_q <= sample.photon_count;
			read_q  <= (sample.opcode == OP_READ);
			range_q <= !neg && ((sample.opcode == OP_READ) ? rd_ok : sp_ok);
		end
		if (state_q == ST_OUT && out_free) begin
			res_range_q <= range_q;
			res_w_q     <= (read_q && range_q) ? rd_w : '0;
			res_i_q     <= (read_q && range_q) ? rd_i : '0;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.in_range      = res_range_q;
	assign result.weight_sum    = res_w_q;
	assign result.intensity_sum = res_i_q;

endmodule

[sv/tvs_chk.sv]
// ----------------------------------------------------------------------------
// tvs_chk
// Port-level checks for the trilinear volume splat block.
// ----------------------------------------------------------------------------
module tvs_chk (
	input logic        clk,
	input logic        arst_n,
	tvs_in_if.sink     sample,
	tvs_out_if.source  result
);

	// an item keeps the block busy for at least the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		sample.valid && sample.ready |=> !sample.ready)
		else $error("ready high right after an accepted item");

	// out-of-range results carry zero sums; the block also zeroes splat sums
	a_zero_when_out: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.in_range |->
			(result.weight_sum == '0) && (result.intensity_sum == '0))
		else $error("nonzero sums on an out-of-range result");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |=> result.valid)
		else $error("result dropped before it was taken");

	a_hold_payload: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |=>
			$stable(result.weight_sum) && $stable(result.intensity_sum))
		else $error("result payload changed while stalled");

endmodule

bind trilinear_volume_splat tvs_chk u_tvs_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.sample (sample),
	.result (result)
);
